// ===== src/xte_pkg.sv =====
// Shared types, character constants and sequence tables for the XML text escaper.
`default_nettype none

package xte_pkg;

    // Opcodes of an input item; the two unused codes behave as raw.
    localparam logic [2:0] OP_CONTENT = 3'd0;
    localparam logic [2:0] OP_ATTR    = 3'd1;
    localparam logic [2:0] OP_CDATA   = 3'd2;
    localparam logic [2:0] OP_COMMENT = 3'd3;
    localparam logic [2:0] OP_PI      = 3'd4;
    localparam logic [2:0] OP_RAW     = 3'd5;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_NL_LENGTH = 2'd0;
    localparam logic [1:0] REG_NL_FIRST  = 2'd1;
    localparam logic [1:0] REG_NL_SECOND = 2'd2;

    localparam logic [15:0] U_LF       = 16'h000A;
    localparam logic [15:0] U_QUOTE    = 16'h0022;
    localparam logic [15:0] U_AMP      = 16'h0026;
    localparam logic [15:0] U_LT       = 16'h003C;
    localparam logic [15:0] U_GT       = 16'h003E;
    localparam logic [15:0] U_QMARK    = 16'h003F;
    localparam logic [15:0] U_HYPHEN   = 16'h002D;
    localparam logic [15:0] U_SPACE    = 16'h0020;
    localparam logic [15:0] U_RBRACKET = 16'h005D;

    localparam logic [15:0] ENT_LT [4] = '{16'h0026, 16'h006C, 16'h0074, 16'h003B};
    localparam logic [15:0] ENT_GT [4] = '{16'h0026, 16'h0067, 16'h0074, 16'h003B};
    localparam logic [15:0] ENT_AMP [5] =
        '{16'h0026, 16'h0061, 16'h006D, 16'h0070, 16'h003B};
    localparam logic [15:0] ENT_QUOT [6] =
        '{16'h0026, 16'h0071, 16'h0075, 16'h006F, 16'h0074, 16'h003B};
    localparam logic [15:0] ENT_LF [5] =
        '{16'h0026, 16'h0023, 16'h0031, 16'h0030, 16'h003B};
    localparam logic [15:0] CDATA_SPLIT [13] = '{
        16'h005D, 16'h005D, 16'h003E, 16'h003C, 16'h0021, 16'h005B, 16'h0043,
        16'h0044, 16'h0041, 16'h0054, 16'h0041, 16'h005B, 16'h003E
    };

    // Output sequence chosen for one input unit.
    typedef enum logic [3:0] {
        SEQ_UNIT,
        SEQ_LT,
        SEQ_GT,
        SEQ_AMP,
        SEQ_QUOT,
        SEQ_LF_ENT,
        SEQ_NEWLINE,
        SEQ_CDATA,
        SEQ_SPACE_BEFORE,
        SEQ_SPACE_AFTER,
        SEQ_SPACE_BOTH
    } seq_kind_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] code_unit;
        logic        last_in_run;
    } item_t;

    typedef struct packed {
        logic [15:0] out_unit;
        logic        last_of_item;
        logic        run_done;
    } result_t;

    typedef struct packed {
        logic [1:0]  newline_length;
        logic [15:0] newline_first;
        logic [15:0] newline_second;
    } cfg_t;

    typedef struct packed {
        logic [15:0] previous_unit;
        logic [1:0]  bracket_count;
    } ctx_t;

    // What the emitter needs to play out one input item.
    typedef struct packed {
        seq_kind_t   kind;
        logic [3:0]  len;
        logic [15:0] unit;
        logic        last;
    } desc_t;

    function automatic logic [15:0] xte_seq_unit(
        input seq_kind_t   kind,
        input logic [3:0]  idx,
        input logic [15:0] unit,
        input logic [15:0] nl_first,
        input logic [15:0] nl_second
    );
        logic [15:0] res;
        res = unit;
        unique case (kind)
            SEQ_UNIT:         res = unit;
            SEQ_LT:           res = ENT_LT[idx[1:0]];
            SEQ_GT:           res = ENT_GT[idx[1:0]];
            SEQ_AMP:          res = ENT_AMP[idx[2:0]];
            SEQ_QUOT:         res = ENT_QUOT[idx[2:0]];
            SEQ_LF_ENT:       res = ENT_LF[idx[2:0]];
            SEQ_NEWLINE:      res = (idx == 4'd0) ? nl_first : nl_second;
            SEQ_CDATA:        res = CDATA_SPLIT[idx];
            SEQ_SPACE_BEFORE: res = (idx == 4'd0) ? U_SPACE : unit;
            SEQ_SPACE_AFTER:  res = (idx == 4'd0) ? unit : U_SPACE;
            SEQ_SPACE_BOTH:   res = (idx == 4'd1) ? unit : U_SPACE;
            default:          res = unit;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/xml_text_escaper.sv =====
// Top level of the XML text escaper: configuration, run context and datapath.
`default_nettype none

//  channel  | signals                                 | direction
//  ---------+-----------------------------------------+----------
//  item     | item_valid, item_ready, item            | in
//  result   | result_valid, result_ready, result      | out
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
//  An item that expands to n units (1 to 13) holds the sequencer until its last
//  unit has gone out; an unchanged unit needs only one, so plain text streams at
//  one transfer per cycle while the result is not stalled. The unit counter in
//  the emitter steps through each item's units. Reset loads the default separator
//  (one LF) and clears the run context and all valid flags. A stalled result holds
//  in the result register while the next unit is already prepared in the item register.

module xml_text_escaper
    import xte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t  cfg_reg;
    ctx_t  ctx_reg;
    ctx_t  ctx_next;
    desc_t desc;
    logic  take_ok;
    logic  item_take;

    // Registers are always writable; the user must write them only while idle, the block does not enforce it.
    assign cfg_ready = 1'b1;

    assign item_ready = take_ok;
    assign item_take  = item_valid && take_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.newline_length <= 2'd1;
            cfg_reg.newline_first  <= U_LF;
            cfg_reg.newline_second <= U_LF;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_NL_LENGTH: cfg_reg.newline_length <= cfg_data[1:0];
                REG_NL_FIRST:  cfg_reg.newline_first  <= cfg_data;
                REG_NL_SECOND: cfg_reg.newline_second <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Advance the run context on every accepted transfer, whatever the mode.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctx_reg <= '0;
        else if (item_take)
            ctx_reg <= ctx_next;
    end

    xte_classify u_classify (
        .item     (item),
        .ctx      (ctx_reg),
        .cfg      (cfg_reg),
        .desc     (desc),
        .ctx_next (ctx_next)
    );

    xte_emitter u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (item_take),
        .desc         (desc),
        .cfg          (cfg_reg),
        .take_ok      (take_ok),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== src/xte_classify.sv =====
// Escape rule selection for one input unit and the next run context.
`default_nettype none

module xte_classify
    import xte_pkg::*;
(
    input  item_t item,
    input  ctx_t  ctx,
    input  cfg_t  cfg,
    output desc_t desc,
    output ctx_t  ctx_next
);

    seq_kind_t   kind;
    logic [15:0] u;
    logic        pre_hyphen;

    assign u          = item.code_unit;
    assign pre_hyphen = (ctx.previous_unit == U_HYPHEN);

    always_comb
    begin
        kind = SEQ_UNIT;
        unique case (item.opcode)
            OP_CONTENT:
            begin
                priority if (u == U_LT) kind = SEQ_LT;
                else if (u == U_GT)     kind = SEQ_GT;
                else if (u == U_AMP)    kind = SEQ_AMP;
                else if (u == U_LF)     kind = SEQ_NEWLINE;
                else                    kind = SEQ_UNIT;
            end
            OP_ATTR:
            begin
                priority if (u == U_LT) kind = SEQ_LT;
                else if (u == U_GT)     kind = SEQ_GT;
                else if (u == U_AMP)    kind = SEQ_AMP;
                else if (u == U_LF)     kind = SEQ_LF_ENT;
                else if (u == U_QUOTE)  kind = SEQ_QUOT;
                else                    kind = SEQ_UNIT;
            end
            OP_CDATA:
            begin
                priority if (u == U_GT && ctx.bracket_count >= 2'd2) kind = SEQ_CDATA;
                else if (u == U_LF)                                 kind = SEQ_NEWLINE;
                else                                                kind = SEQ_UNIT;
            end
            OP_COMMENT:
            begin
                priority if (u != U_HYPHEN)            kind = SEQ_UNIT;
                else if (pre_hyphen && item.last_in_run) kind = SEQ_SPACE_BOTH;
                else if (pre_hyphen)                     kind = SEQ_SPACE_BEFORE;
                else if (item.last_in_run)               kind = SEQ_SPACE_AFTER;
                else                                     kind = SEQ_UNIT;
            end
            OP_PI:
            begin
                if (u == U_GT && ctx.previous_unit == U_QMARK)
                    kind = SEQ_SPACE_BEFORE;
                else
                    kind = SEQ_UNIT;
            end
            default: kind = SEQ_UNIT;
        endcase
    end

    always_comb
    begin
        desc.kind = kind;
        desc.unit = u;
        desc.last = item.last_in_run;
        unique case (kind)
            SEQ_UNIT:         desc.len = 4'd1;
            SEQ_LT:           desc.len = 4'd4;
            SEQ_GT:           desc.len = 4'd4;
            SEQ_AMP:          desc.len = 4'd5;
            SEQ_QUOT:         desc.len = 4'd6;
            SEQ_LF_ENT:       desc.len = 4'd5;
            SEQ_NEWLINE:      desc.len = cfg.newline_length[1] ? 4'd2 : 4'd1;
            SEQ_CDATA:        desc.len = 4'd13;
            SEQ_SPACE_BEFORE: desc.len = 4'd2;
            SEQ_SPACE_AFTER:  desc.len = 4'd2;
            SEQ_SPACE_BOTH:   desc.len = 4'd3;
            default:          desc.len = 4'd1;
        endcase
    end

    // Track the bracket run and the previous unit; clear both at run end.
    always_comb
    begin
        ctx_next.previous_unit = u;
        if (u == U_RBRACKET)
            ctx_next.bracket_count = (ctx.bracket_count < 2'd2) ?
                                     ctx.bracket_count + 2'd1 : ctx.bracket_count;
        else
            ctx_next.bracket_count = 2'd0;
        if (item.last_in_run)
        begin
            ctx_next.previous_unit = '0;
            ctx_next.bracket_count = 2'd0;
        end
    end

endmodule

`default_nettype wire

// ===== src/xte_emitter.sv =====
// Item register, unit sequencer and result register of the escaper.
`default_nettype none

module xte_emitter
    import xte_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  desc_t   desc,
    input  cfg_t    cfg,
    output logic    take_ok,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    desc_t      desc_reg;
    logic       desc_valid_reg;
    logic [3:0] idx_reg;
    logic [3:0] idx_next;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    out_next;
    logic       out_free;
    logic       emit;
    logic       final_unit;

    assign out_free   = !out_valid_reg || result_ready;
    assign emit       = desc_valid_reg && out_free;
    assign final_unit = (idx_reg == desc_reg.len - 4'd1);
    assign take_ok    = !desc_valid_reg || (emit && final_unit);
    assign idx_next   = idx_reg + 4'd1;

    always_comb
    begin
        out_next.out_unit     = xte_seq_unit(desc_reg.kind, idx_reg, desc_reg.unit,
                                             cfg.newline_first, cfg.newline_second);
        out_next.last_of_item = final_unit;
        out_next.run_done     = final_unit && desc_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_valid_reg <= 1'b0;
            idx_reg        <= 4'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                desc_valid_reg <= 1'b1;
                idx_reg        <= 4'd0;
            end
            else if (emit && final_unit)
                desc_valid_reg <= 1'b0;
            else if (emit)
                idx_reg <= idx_next;

            if (emit)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            desc_reg <= desc;
        if (emit)
            out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the XML text escaper: directed table, random runs, scoreboard.
`default_nettype none

module tb;
    import xte_pkg::*;

    // The two spare opcodes have no name in the package; they behave as raw.
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;
    localparam logic [2:0] OPCODES [8] = '{
        OP_CONTENT, OP_ATTR, OP_CDATA, OP_COMMENT, OP_PI, OP_RAW, OP_SPARE6, OP_SPARE7
    };
    localparam logic [1:0] REG_ORDER [3] = '{REG_NL_LENGTH, REG_NL_FIRST, REG_NL_SECOND};

    // Characters the escaping rules look at, kept apart from the design's own table.
    localparam logic [15:0] CH_LF       = 16'h000A;
    localparam logic [15:0] CH_SPACE    = 16'h0020;
    localparam logic [15:0] CH_QUOTE    = 16'h0022;
    localparam logic [15:0] CH_AMP      = 16'h0026;
    localparam logic [15:0] CH_HYPHEN   = 16'h002D;
    localparam logic [15:0] CH_LT       = 16'h003C;
    localparam logic [15:0] CH_GT       = 16'h003E;
    localparam logic [15:0] CH_QMARK    = 16'h003F;
    localparam logic [15:0] CH_RBRACKET = 16'h005D;
    localparam logic [15:0] CH_ZERO     = 16'h0000;
    localparam logic [15:0] CH_ALLONES  = 16'hFFFF;
    localparam logic [15:0] SPECIALS [11] = '{
        CH_LT, CH_GT, CH_AMP, CH_QUOTE, CH_LF, CH_RBRACKET,
        CH_HYPHEN, CH_QMARK, CH_SPACE, CH_ZERO, CH_ALLONES
    };

    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 52;
    localparam int TAIL_CYCLES     = 32;
    localparam int WATCHDOG_LIMIT  = 5000;

    // One row of the directed table. Where typed is set the result is a single
    // unit that can be read straight off the rules; the predictor covers the rest.
    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] code_unit;
        logic        last_in_run;
        logic        typed;
        logic [15:0] typed_unit;
    } dir_row_t;

    localparam int N_DIRECTED = 25;
    localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // content: extremes, the three entities, separator at run end
        '{OP_CONTENT, CH_ZERO,     1'b0, 1'b1, CH_ZERO},
        '{OP_CONTENT, CH_ALLONES,  1'b0, 1'b1, CH_ALLONES},
        '{OP_CONTENT, CH_LT,       1'b0, 1'b0, CH_ZERO},
        '{OP_CONTENT, CH_GT,       1'b0, 1'b0, CH_ZERO},
        '{OP_CONTENT, CH_AMP,      1'b0, 1'b0, CH_ZERO},
        '{OP_CONTENT, CH_LF,       1'b1, 1'b1, CH_LF},
        // attribute: quote, LF entity, an entity closing the run
        '{OP_ATTR,    CH_QUOTE,    1'b0, 1'b0, CH_ZERO},
        '{OP_ATTR,    CH_LF,       1'b0, 1'b0, CH_ZERO},
        '{OP_ATTR,    CH_LT,       1'b1, 1'b0, CH_ZERO},
        // CDATA: three brackets then '>', only the last two match; count restarts
        '{OP_CDATA,   CH_RBRACKET, 1'b0, 1'b1, CH_RBRACKET},
        '{OP_CDATA,   CH_RBRACKET, 1'b0, 1'b1, CH_RBRACKET},
        '{OP_CDATA,   CH_RBRACKET, 1'b0, 1'b1, CH_RBRACKET},
        '{OP_CDATA,   CH_GT,       1'b0, 1'b0, CH_ZERO},
        '{OP_CDATA,   CH_GT,       1'b1, 1'b1, CH_GT},
        // comment: hyphen pair, zero unit as data, trailing hyphen
        '{OP_COMMENT, CH_HYPHEN,   1'b0, 1'b1, CH_HYPHEN},
        '{OP_COMMENT, CH_HYPHEN,   1'b0, 1'b0, CH_ZERO},
        '{OP_COMMENT, CH_ZERO,     1'b0, 1'b1, CH_ZERO},
        '{OP_COMMENT, CH_HYPHEN,   1'b1, 1'b0, CH_ZERO},
        // processing instruction close
        '{OP_PI,      CH_QMARK,    1'b0, 1'b1, CH_QMARK},
        '{OP_PI,      CH_GT,       1'b1, 1'b0, CH_ZERO},
        // raw and spare opcodes pass unchanged
        '{OP_RAW,     CH_LT,       1'b0, 1'b1, CH_LT},
        '{OP_SPARE6,  CH_AMP,      1'b0, 1'b1, CH_AMP},
        // mixed modes: brackets seen under other opcodes still arm the split
        '{OP_SPARE7,  CH_RBRACKET, 1'b0, 1'b1, CH_RBRACKET},
        '{OP_CDATA,   CH_RBRACKET, 1'b0, 1'b1, CH_RBRACKET},
        '{OP_CDATA,   CH_GT,       1'b1, 1'b0, CH_ZERO}
    };

    // Block ports; every input holds a known value from time zero.
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_ready;
    item_t       item         = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    result_t     result;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index    = REG_NL_LENGTH;
    logic [15:0] cfg_data     = '0;

    // Sideband that travels with a directed row into the scoreboard.
    logic        row_typed    = 1'b0;
    logic [15:0] row_unit     = '0;

    // Predictor copy of the registers and the run context.
    logic [1:0]  nl_len    = 2'd1;
    logic [15:0] nl_first  = CH_LF;
    logic [15:0] nl_second = CH_LF;
    logic [15:0] prev_unit = '0;
    logic [1:0]  rbr_count = '0;

    logic [15:0] esc_units [$];   // escaped units of the item being predicted
    result_t     escaped_q [$];   // escaped results still owed by the block

    int send_idle    = 0;
    int recv_stall   = 0;
    int err_count    = 0;
    int items_seen   = 0;
    int runs_seen    = 0;
    int results_seen = 0;
    int cfg_writes   = 0;
    int idle_cycles  = 0;

    xml_text_escaper uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Add one unit to the tail of the predicted sequence.
    function automatic void add_unit(input logic [15:0] x);
        esc_units.insert(esc_units.size(), x);
    endfunction

    // Queue one result that the block owes.
    function automatic void owe_result(input result_t r);
        escaped_q.insert(escaped_q.size(), r);
    endfunction

    // Append an ASCII string as UTF-16 units.
    function automatic void put_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            add_unit({8'h00, s[i]});
    endfunction

    function automatic void put_newline();
        add_unit(nl_first);
        // lengths 2 and 3 both emit the second unit; 0 and 1 only the first
        if (nl_len >= 2'd2)
            add_unit(nl_second);
    endfunction

    // Work out the escaped units of one item and advance the run context.
    function automatic void escape_item(input item_t it);
        logic [15:0] u;
        u = it.code_unit;
        esc_units.delete();
        case (it.opcode)
            OP_CONTENT, OP_ATTR: begin
                if (u == CH_LT)
                    put_text("&lt;");
                else if (u == CH_GT)
                    put_text("&gt;");
                else if (u == CH_AMP)
                    put_text("&amp;");
                else if (u == CH_LF && it.opcode == OP_ATTR)
                    put_text("&#10;");
                else if (u == CH_LF)
                    put_newline();
                else if (u == CH_QUOTE && it.opcode == OP_ATTR)
                    put_text("&quot;");
                else
                    add_unit(u);
            end
            OP_CDATA: begin
                // the two brackets already went out unchanged, so repeat them here
                if (u == CH_GT && rbr_count >= 2'd2)
                    put_text("]]><![CDATA[>");
                else if (u == CH_LF)
                    put_newline();
                else
                    add_unit(u);
            end
            OP_COMMENT: begin
                if (u == CH_HYPHEN && prev_unit == CH_HYPHEN)
                    add_unit(CH_SPACE);
                add_unit(u);
                if (u == CH_HYPHEN && it.last_in_run)
                    add_unit(CH_SPACE);
            end
            OP_PI: begin
                if (u == CH_GT && prev_unit == CH_QMARK)
                    add_unit(CH_SPACE);
                add_unit(u);
            end
            default: add_unit(u);
        endcase

        // Every opcode feeds the context; a run end clears it.
        if (u == CH_RBRACKET) begin
            if (rbr_count < 2'd2)
                rbr_count = rbr_count + 2'd1;
        end
        else
            rbr_count = 2'd0;
        prev_unit = u;
        if (it.last_in_run) begin
            prev_unit = '0;
            rbr_count = 2'd0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly real opcodes, with the spare codes as occasional noise.
    function automatic logic [2:0] pick_opcode();
        if ($urandom_range(0, 99) < 6)
            return OPCODES[$urandom_range(6, 7)];
        return OPCODES[$urandom_range(0, 5)];
    endfunction

    // Lean on the characters each mode reacts to, so that bracket runs,
    // hyphen pairs and '?>' turn up often; the rest is printable or any unit.
    function automatic logic [15:0] pick_unit(input logic [2:0] op);
        int r;
        r = $urandom_range(0, 99);
        if (op == OP_CDATA) begin
            if (r < 40)
                return CH_RBRACKET;
            if (r < 60)
                return CH_GT;
        end
        else if (op == OP_COMMENT) begin
            if (r < 45)
                return CH_HYPHEN;
        end
        else if (op == OP_PI) begin
            if (r < 30)
                return CH_QMARK;
            if (r < 55)
                return CH_GT;
        end
        r = $urandom_range(0, 99);
        if (r < 40)
            return SPECIALS[$urandom_range(0, 10)];
        if (r < 70)
            return 16'($urandom_range(16'h0020, 16'h007E));
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    // Present one item and hold it until the transfer. Entered and left just
    // after a falling edge; valid gets at most one update per falling edge.
    task automatic send_item(input item_t it, input logic typed, input logic [15:0] unit);
        while ($urandom_range(0, 99) < send_idle) begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item       <= it;
        row_typed  <= typed;
        row_unit   <= unit;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        @(negedge clk);
    endtask

    // Drop valid and hold the sender until every owed result has come back.
    task automatic drain_results();
        item_valid <= 1'b0;
        @(negedge clk);
        while (escaped_q.size() != 0)
            @(negedge clk);
    endtask

    // Write all three registers back to back, only with the block idle.
    task automatic write_config(input cfg_t c);
        logic [15:0] value [3];
        int          idx;
        value[0] = {14'd0, c.newline_length};
        value[1] = c.newline_first;
        value[2] = c.newline_second;
        for (idx = 0; idx < 3; idx++) begin
            cfg_index <= REG_ORDER[idx];
            cfg_data  <= value[idx];
            cfg_valid <= 1'b1;
            do
                @(posedge clk);
            while (!cfg_ready);
            case (REG_ORDER[idx])
                REG_NL_LENGTH: nl_len    = value[idx][1:0];
                REG_NL_FIRST:  nl_first  = value[idx];
                REG_NL_SECOND: nl_second = value[idx];
                default: ;
            endcase
            cfg_writes++;
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic report_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall at the falling edge as the current phase asks.
    // ------------------------------------------------------------------
    always @(negedge clk)
        result_ready <= ($urandom_range(0, 99) >= recv_stall);

    // ------------------------------------------------------------------
    // Scoreboard and watchdog. Prediction and checking share one process,
    // so prediction always runs before checking.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        result_t want;
        result_t owed;
        int      k;
        if (rst_n) begin
            idle_cycles++;
            if (item_valid && item_ready) begin
                idle_cycles = 0;
                items_seen++;
                if (item.last_in_run)
                    runs_seen++;
                escape_item(item);
                if (row_typed) begin
                    owed.out_unit     = row_unit;
                    owed.last_of_item = 1'b1;
                    owed.run_done     = item.last_in_run;
                    owe_result(owed);
                end
                else begin
                    for (k = 0; k < esc_units.size(); k++) begin
                        owed.out_unit     = esc_units[k];
                        owed.last_of_item = (k == esc_units.size() - 1);
                        owed.run_done     = owed.last_of_item & item.last_in_run;
                        owe_result(owed);
                    end
                end
            end
            if (result_valid && result_ready) begin
                idle_cycles = 0;
                results_seen++;
                if (escaped_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h/%b/%b",
                             $time, result.out_unit, result.last_of_item, result.run_done);
                    err_count++;
                end
                else begin
                    want = escaped_q.pop_front();
                    if (result.out_unit !== want.out_unit)
                        report_field("out_unit", want.out_unit, result.out_unit);
                    if (result.last_of_item !== want.last_of_item)
                        report_field("last_of_item", 16'(want.last_of_item),
                                     16'(result.last_of_item));
                    if (result.run_done !== want.run_done)
                        report_field("run_done", 16'(want.run_done), 16'(result.run_done));
                end
            end
            if (cfg_valid && cfg_ready)
                idle_cycles = 0;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results still owed",
                         $time, idle_cycles, escaped_q.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        cfg_t       setting;
        item_t      it;
        logic [2:0] run_op;
        logic       mixed;
        int         p;
        int         i;
        int         len;
        int         left;

        // Hold reset from time zero, release it once and never again.
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed table under the reset separator, no idling.
        for (i = 0; i < N_DIRECTED; i++) begin
            it.opcode      = DIRECTED_ROWS[i].opcode;
            it.code_unit   = DIRECTED_ROWS[i].code_unit;
            it.last_in_run = DIRECTED_ROWS[i].last_in_run;
            send_item(it, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].typed_unit);
        end
        // The sender pauses here until every owed result has arrived.
        drain_results();

        // Random phases: a separator setting each and one of four idling patterns in turn.
        for (p = 0; p < N_PHASES; p++) begin
            case (p)
                0: setting = '{2'd1, CH_LF, CH_LF};
                1: setting = '{2'd2, 16'h000D, CH_LF};
                2: setting = '{2'd0, CH_ALLONES, CH_ZERO};
                3: setting = '{2'd3, CH_ZERO, CH_ALLONES};
                4: setting = '{2'd2, 16'($urandom_range(0, 16'hFFFF)),
                               16'($urandom_range(0, 16'hFFFF))};
                5: setting = '{2'd1, 16'($urandom_range(0, 16'hFFFF)), CH_ALLONES};
                6: setting = '{2'd2, CH_ALLONES, CH_ALLONES};
                default: setting = '{2'($urandom_range(0, 3)),
                                     16'($urandom_range(0, 16'hFFFF)),
                                     16'($urandom_range(0, 16'hFFFF))};
            endcase
            write_config(setting);

            case (p % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 76; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 76; end
                default: begin send_idle = 35; recv_stall = 35; end
            endcase

            // Short runs, mostly one mode each, some mixing modes unit by unit.
            left = ITEMS_PER_PHASE;
            while (left > 0) begin
                len = $urandom_range(1, 10);
                if (len > left)
                    len = left;
                run_op = pick_opcode();
                mixed  = ($urandom_range(0, 99) < 20);
                for (i = 0; i < len; i++) begin
                    it.opcode      = mixed ? pick_opcode() : run_op;
                    it.code_unit   = pick_unit(it.opcode);
                    it.last_in_run = (i == len - 1);
                    send_item(it, 1'b0, CH_ZERO);
                end
                left -= len;
            end
            drain_results();
        end

        // Allow for any stray output after the last owed result.
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Covered %0d items in %0d runs, %0d escaped units checked,",
                 items_seen, runs_seen, results_seen);
        $display("%0d register writes over %0d separator settings and four idling patterns.",
                 cfg_writes, N_PHASES);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
